@@ rtl/core/sgfe_pkg.sv @@
// Shared types, widths and constants for the stepped-gradient field evaluator.
// Depends on nothing; every other file of the block but sgfe_stream_if imports it.
package sgfe_pkg;

  // Field and coordinate widths
  localparam int DATA_W  = 32;           // Q16.16 fields, Q8.24 positions
  localparam int LEN_W   = 31;           // half length, unsigned Q8.24
  localparam int ADDR_W  = 4;            // four registers at 4-byte spacing

  // Internal arithmetic widths
  localparam int GRAD_W  = DATA_W + 1;   // gradient in effect, holds -beta exactly
  localparam int RAD_W   = 2 * DATA_W;   // x^2 + y^2
  localparam int ROOT_W  = DATA_W;       // floor of the radius
  localparam int REM_W   = ROOT_W + 2;   // square-root partial remainder
  localparam int LOW_W   = 32;           // split point of the wide products
  localparam int SUM_W   = 65;           // 1 + alpha*r + g*z in Q.40, also g*z
  localparam int PROD_W  = 97;           // full product ahead of rounding

  // Square root: two root bits resolved per stage
  localparam int SQRT_STEPS  = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  // Stage counts of each section, and the delays that line them up
  localparam int FRONT_RAD_LAT  = 3;     // radicand and g*z leave the front end
  localparam int FRONT_PROD_LAT = 4;     // transverse products leave the front end
  localparam int ZPATH_LAT      = 4;
  localparam int ROUND_LAT      = 2;
  localparam int ROOT_LAT       = FRONT_RAD_LAT + SQRT_STAGES;
  localparam int TOTAL_LAT      = ROOT_LAT + ZPATH_LAT + ROUND_LAT;
  localparam int GZ_DELAY       = ROOT_LAT - FRONT_RAD_LAT;
  localparam int XY_DELAY       = TOTAL_LAT - FRONT_PROD_LAT - ROUND_LAT;

  // Fraction bits dropped when rounding to Q16.16
  localparam int XY_SHIFT = 41;          // 40 of the 56 fraction bits plus the factor of one half
  localparam int Z_SHIFT  = 40;

  // 1.0 in Q.40
  localparam logic [SUM_W-1:0] UNITY_Q40 = {{(SUM_W - 41){1'b0}}, 1'b1, 40'd0};

  // Saturation limits, as magnitudes and as results
  localparam logic [DATA_W:0]   SAT_NEG_MAG = 33'h0_8000_0000;
  localparam logic [DATA_W:0]   SAT_POS_MAG = 33'h0_7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] SAT_POS     = 32'h7FFF_FFFF;

  // Register map
  typedef enum logic [1:0] {
    REG_BASE_FIELD      = 2'd0,
    REG_RADIAL_GRADIENT = 2'd1,
    REG_AXIAL_GRADIENT  = 2'd2,
    REG_HALF_LENGTH     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] base_field;
    logic signed [DATA_W-1:0] radial_gradient;
    logic signed [DATA_W-1:0] axial_gradient;
    logic        [LEN_W-1:0]  half_length;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
    logic                     overflow;
  } field_t;

endpackage

@@ rtl/core/sgfe_stream_if.sv @@
// Valid/ready stream channel carrying one request payload.
// The payload type is supplied by the instantiating level (types from sgfe_pkg).
interface sgfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/sgfe_regs.sv @@
// APB-style configuration registers of the field evaluator.
// Depends on sgfe_pkg for the register map and the configuration struct.
module sgfe_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sgfe_pkg::ADDR_W-1:0] paddr,
  input  logic [sgfe_pkg::DATA_W-1:0] pwdata,
  output logic [sgfe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sgfe_pkg::cfg_t              cfg
);
  import sgfe_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_BASE_FIELD:      cfg.base_field      <= $signed(pwdata);
        REG_RADIAL_GRADIENT: cfg.radial_gradient <= $signed(pwdata);
        REG_AXIAL_GRADIENT:  cfg.axial_gradient  <= $signed(pwdata);
        REG_HALF_LENGTH:     cfg.half_length     <= pwdata[LEN_W-1:0];
        default:             cfg                 <= cfg;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_BASE_FIELD:      prdata = cfg.base_field;
      REG_RADIAL_GRADIENT: prdata = cfg.radial_gradient;
      REG_AXIAL_GRADIENT:  prdata = cfg.axial_gradient;
      REG_HALF_LENGTH:     prdata = {1'b0, cfg.half_length};
      default:             prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/sgfe_front.sv @@
// Front end of the evaluator: gradient selection, magnitudes, squares and the
// transverse products B0*(-g)*x and B0*(-g)*y. Depends on sgfe_pkg.
module sgfe_front (
  input  logic                               clk,
  input  logic                               adv,
  input  sgfe_pkg::cfg_t                     cfg,
  input  sgfe_pkg::pos_t                     pos,
  output logic        [sgfe_pkg::RAD_W-1:0]  radicand,
  output logic signed [sgfe_pkg::SUM_W-1:0]  gz,
  output logic signed [sgfe_pkg::PROD_W-1:0] prod_x,
  output logic signed [sgfe_pkg::PROD_W-1:0] prod_y
);
  import sgfe_pkg::*;

  localparam int PL_W = LOW_W + 1 + GRAD_W;   // unsigned low half times gradient
  localparam int PH_W = RAD_W - LOW_W + GRAD_W;

  // Stage 1 signals
  logic signed [GRAD_W-1:0] z_e, len_p, len_n, beta_e, g_c;
  logic        [DATA_W-1:0] ax_c, ay_c;
  logic        [DATA_W-1:0] ax1, ay1;
  logic signed [DATA_W-1:0] x1, y1, z1;
  logic signed [GRAD_W-1:0] g1;

  // Stage 2 signals
  logic        [RAD_W-1:0]  sqx2, sqy2;
  logic signed [RAD_W-1:0]  b0x2, b0y2;
  logic signed [SUM_W-1:0]  gz2;
  logic signed [GRAD_W-1:0] ng2;

  // Stage 3 signals
  logic signed [PL_W-1:0]   plx3, ply3;
  logic signed [PH_W-1:0]   phx3, phy3;

  // Pick the gradient in effect from the axial position
  always_comb begin
    z_e    = {pos.pos_z[DATA_W-1], pos.pos_z};
    len_p  = {2'b00, cfg.half_length};
    len_n  = -len_p;
    beta_e = {cfg.axial_gradient[DATA_W-1], cfg.axial_gradient};
    if ((z_e > len_n) && (z_e < len_p)) begin
      g_c = '0;
    end else if (z_e <= len_n) begin
      g_c = -beta_e;
    end else begin
      g_c = beta_e;
    end
    ax_c = pos.pos_x[DATA_W-1] ? DATA_W'(-pos.pos_x) : DATA_W'(pos.pos_x);
    ay_c = pos.pos_y[DATA_W-1] ? DATA_W'(-pos.pos_y) : DATA_W'(pos.pos_y);
  end

  // Stage 1: gradient and magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      ax1 <= ax_c;
      ay1 <= ay_c;
      x1  <= pos.pos_x;
      y1  <= pos.pos_y;
      z1  <= pos.pos_z;
      g1  <= g_c;
    end
  end

  // Stage 2: squares, B0 products and g*z
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx2 <= RAD_W'(ax1) * RAD_W'(ax1);
      sqy2 <= RAD_W'(ay1) * RAD_W'(ay1);
      b0x2 <= RAD_W'(cfg.base_field) * RAD_W'(x1);
      b0y2 <= RAD_W'(cfg.base_field) * RAD_W'(y1);
      gz2  <= SUM_W'(g1) * SUM_W'(z1);
      ng2  <= -g1;
    end
  end

  // Stage 3: radicand sum and split products by the negated gradient
  always_ff @(posedge clk) begin
    if (adv) begin
      radicand <= sqx2 + sqy2;
      gz       <= gz2;
      plx3     <= PL_W'($signed({1'b0, b0x2[LOW_W-1:0]})) * PL_W'(ng2);
      phx3     <= PH_W'($signed(b0x2[RAD_W-1:LOW_W])) * PH_W'(ng2);
      ply3     <= PL_W'($signed({1'b0, b0y2[LOW_W-1:0]})) * PL_W'(ng2);
      phy3     <= PH_W'($signed(b0y2[RAD_W-1:LOW_W])) * PH_W'(ng2);
    end
  end

  // Stage 4: recombine the halves
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x <= (PROD_W'(phx3) <<< LOW_W) + PROD_W'(plx3);
      prod_y <= (PROD_W'(phy3) <<< LOW_W) + PROD_W'(ply3);
    end
  end

endmodule

@@ rtl/core/sgfe_sqrt.sv @@
// Pipelined integer square root of the Q16.48 radius squared.
// Restoring digit recurrence, SQRT_STEPS root bits per stage. Depends on sgfe_pkg.
module sgfe_sqrt (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [sgfe_pkg::RAD_W-1:0]  radicand,
  output logic [sgfe_pkg::ROOT_W-1:0] root
);
  import sgfe_pkg::*;

  localparam int TRIAL_W = REM_W + 2;

  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [REM_W-1:0]   rem_in, rem_c;
    logic [ROOT_W-1:0]  root_in, root_c;
    logic [RAD_W-1:0]   rad_in, rad_c;
    logic [TRIAL_W-1:0] trial, test;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    // Resolve the next root bits, bringing down two radicand bits each
    always_comb begin
      rem_c  = rem_in;
      root_c = root_in;
      rad_c  = rad_in;
      trial  = '0;
      test   = '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        trial = {rem_c, rad_c[RAD_W-1 -: 2]};
        test  = TRIAL_W'({root_c, 2'b01});
        if (trial >= test) begin
          rem_c  = REM_W'(trial - test);
          root_c = {root_c[ROOT_W-2:0], 1'b1};
        end else begin
          rem_c  = REM_W'(trial);
          root_c = {root_c[ROOT_W-2:0], 1'b0};
        end
        rad_c = rad_c << 2;
      end
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[s]  <= rem_c;
        root_q[s] <= root_c;
        rad_q[s]  <= rad_c;
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

@@ rtl/core/sgfe_zpath.sv @@
// Axial component path: forms B0*(1 + alpha*r + g*z) exactly ahead of rounding.
// Depends on sgfe_pkg.
module sgfe_zpath (
  input  logic                               clk,
  input  logic                               adv,
  input  sgfe_pkg::cfg_t                     cfg,
  input  logic        [sgfe_pkg::ROOT_W-1:0] root,
  input  logic signed [sgfe_pkg::SUM_W-1:0]  gz,
  output logic signed [sgfe_pkg::PROD_W-1:0] prod_z
);
  import sgfe_pkg::*;

  localparam int HI_W = SUM_W - LOW_W;

  logic signed [SUM_W-1:0] ar1, gz1, s2, pl3, ph3;

  // Stage 1: alpha times the radius
  always_ff @(posedge clk) begin
    if (adv) begin
      ar1 <= SUM_W'(cfg.radial_gradient) * SUM_W'($signed({1'b0, root}));
      gz1 <= gz;
    end
  end

  // Stage 2: scale factor in Q.40
  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= $signed(UNITY_Q40) + ar1 + gz1;
    end
  end

  // Stage 3: split the scale factor and multiply by B0
  always_ff @(posedge clk) begin
    if (adv) begin
      pl3 <= SUM_W'($signed({1'b0, s2[LOW_W-1:0]})) * SUM_W'(cfg.base_field);
      ph3 <= SUM_W'($signed(s2[SUM_W-1 -: HI_W])) * SUM_W'(cfg.base_field);
    end
  end

  // Stage 4: recombine the halves
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_z <= (PROD_W'(ph3) <<< LOW_W) + PROD_W'(pl3);
    end
  end

endmodule

@@ rtl/core/sgfe_round.sv @@
// Two-stage round-to-nearest (ties away from zero) and saturation to Q16.16.
// SHIFT is the number of fraction bits dropped. Depends on sgfe_pkg.
module sgfe_round #(
  parameter int SHIFT = 40
) (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [sgfe_pkg::PROD_W-1:0] value,
  output logic signed [sgfe_pkg::DATA_W-1:0] result,
  output logic                               sat
);
  import sgfe_pkg::*;

  localparam int MAG_W = PROD_W + 1;
  localparam int Q_W   = MAG_W - SHIFT;
  localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (SHIFT - 1);

  logic              neg_c, neg1;
  logic [MAG_W-1:0]  mag_c, mag1;
  logic [Q_W-1:0]    q, lim;
  logic              over;
  logic [DATA_W-1:0] res_c;

  // Magnitude plus one half; a negative value folds its +1 into the addend
  always_comb begin
    neg_c = value[PROD_W-1];
    mag_c = neg_c ? (MAG_W'(~value) + HALF + MAG_W'(1)) : (MAG_W'(value) + HALF);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1 <= mag_c;
      neg1 <= neg_c;
    end
  end

  // Drop the fraction, clamp and restore the sign
  always_comb begin
    q     = mag1[MAG_W-1:SHIFT];
    lim   = neg1 ? Q_W'(SAT_NEG_MAG) : Q_W'(SAT_POS_MAG);
    over  = q > lim;
    if (over) begin
      res_c = neg1 ? SAT_NEG : SAT_POS;
    end else begin
      res_c = neg1 ? -q[DATA_W-1:0] : q[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= $signed(res_c);
      sat    <= over;
    end
  end

endmodule

@@ rtl/core/stepped_gradient_field_eval.sv @@
// Stepped-gradient magnetic field evaluator: one position request in, one field
// vector out. Depends on sgfe_pkg, sgfe_stream_if and the sgfe_* section modules.
//
// A position request is accepted every cycle while the skid register is free;
// its field leaves through an output register. The depth is set by the 16-stage
// square root of x^2 + y^2 (two root bits per stage) with three front-end stages
// ahead of it and four multiply stages plus two rounding stages behind it. The
// transverse components are finished early and held in a delay line until the
// axial one catches up. On a stall on the result side a skid register catches
// the request in flight and then freezes the whole pipeline, so nothing is
// lost or repeated. Configuration registers are read directly by the datapath
// and must be written only while no request is in flight.
module stepped_gradient_field_eval (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sgfe_pkg::ADDR_W-1:0] paddr,
  input  logic [sgfe_pkg::DATA_W-1:0] pwdata,
  output logic [sgfe_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  sgfe_stream_if.sink                 sample,
  sgfe_stream_if.source               result
);
  import sgfe_pkg::*;

  cfg_t                     cfg;
  logic                     adv;
  logic [TOTAL_LAT-1:0]     vld;

  logic        [RAD_W-1:0]  radicand;
  logic        [ROOT_W-1:0] root;
  logic signed [SUM_W-1:0]  gz;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic signed [DATA_W-1:0] fx, fy, fz;
  logic                     sat_x, sat_y, sat_z;

  logic signed [SUM_W-1:0]  gz_d  [GZ_DELAY];
  logic signed [DATA_W-1:0] fx_d  [XY_DELAY];
  logic signed [DATA_W-1:0] fy_d  [XY_DELAY];
  logic                     sxy_d [XY_DELAY];

  field_t                   fin;
  logic                     push, pop;
  field_t                   out_data, skid_data;
  logic                     out_vld, skid_vld;

  // Configuration
  sgfe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline moves whenever the skid register is free
  assign adv          = !skid_vld;
  assign sample.ready = adv;

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL_LAT-2:0], sample.valid};
    end
  end

  sgfe_front u_front (
    .clk      (clk),
    .adv      (adv),
    .cfg      (cfg),
    .pos      (sample.data),
    .radicand (radicand),
    .gz       (gz),
    .prod_x   (prod_x),
    .prod_y   (prod_y)
  );

  sgfe_round #(.SHIFT(XY_SHIFT)) u_round_x (
    .clk    (clk),
    .adv    (adv),
    .value  (prod_x),
    .result (fx),
    .sat    (sat_x)
  );

  sgfe_round #(.SHIFT(XY_SHIFT)) u_round_y (
    .clk    (clk),
    .adv    (adv),
    .value  (prod_y),
    .result (fy),
    .sat    (sat_y)
  );

  sgfe_sqrt u_sqrt (
    .clk      (clk),
    .adv      (adv),
    .radicand (radicand),
    .root     (root)
  );

  // Hold g*z until the radius is ready
  always_ff @(posedge clk) begin
    if (adv) begin
      gz_d[0] <= gz;
      for (int i = 1; i < GZ_DELAY; i++) begin
        gz_d[i] <= gz_d[i-1];
      end
    end
  end

  sgfe_zpath u_zpath (
    .clk    (clk),
    .adv    (adv),
    .cfg    (cfg),
    .root   (root),
    .gz     (gz_d[GZ_DELAY-1]),
    .prod_z (prod_z)
  );

  sgfe_round #(.SHIFT(Z_SHIFT)) u_round_z (
    .clk    (clk),
    .adv    (adv),
    .value  (prod_z),
    .result (fz),
    .sat    (sat_z)
  );

  // Hold the transverse components until the axial one is done
  always_ff @(posedge clk) begin
    if (adv) begin
      fx_d[0]  <= fx;
      fy_d[0]  <= fy;
      sxy_d[0] <= sat_x || sat_y;
      for (int i = 1; i < XY_DELAY; i++) begin
        fx_d[i]  <= fx_d[i-1];
        fy_d[i]  <= fy_d[i-1];
        sxy_d[i] <= sxy_d[i-1];
      end
    end
  end

  // Assemble the finished field vector
  always_comb begin
    fin.field_x  = fx_d[XY_DELAY-1];
    fin.field_y  = fy_d[XY_DELAY-1];
    fin.field_z  = fz;
    fin.overflow = sxy_d[XY_DELAY-1] || sat_z;
  end

  assign push = adv && vld[TOTAL_LAT-1];
  assign pop  = out_vld && result.ready;

  // Output register with skid: drain the skid first, else take the new request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (pop) begin
        out_data <= skid_data;
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld || pop) begin
        out_data <= fin;
        out_vld  <= 1'b1;
      end else begin
        skid_data <= fin;
        skid_vld  <= 1'b1;
      end
    end else if (pop) begin
      out_vld <= 1'b0;
    end
  end

  assign result.valid = out_vld;
  assign result.data  = out_data;

endmodule
